@@ design/smrd_pkg.sv @@
// Package for the sign-magnitude Rice decoder: widths, phase codes,
// decoder state type and the sample reconstruction function.
// No dependencies.
package smrd_pkg;

    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int QUOT_W   = 16;
    localparam int REM_W    = 15;
    localparam int K_W      = 4;
    localparam int MAX_RES  = 4;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    localparam logic [K_W-1:0] RESET_K = K_W'(5);

    // Decode phases; the unused code behaves like PH_SIGN
    localparam logic [1:0] PH_SIGN = 2'd0;
    localparam logic [1:0] PH_QUOT = 2'd1;
    localparam logic [1:0] PH_REM  = 2'd2;

    typedef struct packed {
        logic [1:0]        phase;
        logic              neg;
        logic [QUOT_W-1:0] quot;
        logic [REM_W-1:0]  rem;
        logic [K_W-1:0]    left;
    } t_dec_state;

    // Rebuild a sample: (q << k) | r, truncated, negated for a set sign
    function automatic logic [SAMPLE_W-1:0] f_sample(
        input logic              neg,
        input logic [QUOT_W-1:0] quot,
        input logic [REM_W-1:0]  rem,
        input logic [K_W-1:0]    k
    );
        logic [SAMPLE_W-1:0] mag;
        mag = SAMPLE_W'(quot << k) | SAMPLE_W'(rem);
        return neg ? SAMPLE_W'(-mag) : mag;
    endfunction

endpackage

@@ design/sign_magnitude_rice_decoder.sv @@
// Sign-magnitude Rice decoder top level: byte input register, unrolled
// eight-bit decode, result buffer of up to four samples and output drain.
// Depends on smrd_pkg.

// A byte stream enters on the slave side, one byte per beat, bits taken
// MSB first. Each code is a sign bit, a unary quotient of ones ended by a
// zero and k remainder bits (k from the configuration register, reset 5).
// Every finished code leaves as one 16-bit two's complement sample on the
// master side; tlast marks the last sample finished within a byte. Codes
// may span bytes, and a partial code is held until more bytes arrive. A
// byte is held in the input register, then decoded into the result buffer,
// which shows its first sample. A byte that finishes n samples occupies
// the result buffer for n output beats, so the input takes one byte per
// cycle while each byte finishes at most one sample and the output is
// ready; more samples stall the input while the single port drains them.
// Write rice_param only while no byte is held and no sample is pending.
module sign_magnitude_rice_decoder
    import smrd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration: rice_param
    input  logic                i_cfg_we,
    input  logic [K_W-1:0]      i_cfg_wdata,
    // Input stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [BYTE_W-1:0]   i_s_axis_tdata,   // [7:0] code_byte
    // Output stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [SAMPLE_W-1:0] o_m_axis_tdata,   // [15:0] sample
    output logic                o_m_axis_tlast    // last_of_byte
);

    logic [K_W-1:0]       r_k;
    logic                 r_in_vld;
    logic [BYTE_W-1:0]    r_in_byte;
    t_dec_state           r_st;
    t_dec_state           n_st;
    logic [SAMPLE_W-1:0]  r_res [MAX_RES];
    logic [SAMPLE_W-1:0]  n_res [MAX_RES];
    logic [RES_CNT_W-1:0] r_res_cnt;
    logic [RES_CNT_W-1:0] n_cnt;
    logic [RES_IDX_W-1:0] r_res_idx;

    logic                 slot_neg  [MAX_RES];
    logic [QUOT_W-1:0]    slot_quot [MAX_RES];
    logic [REM_W-1:0]     slot_rem  [MAX_RES];
    logic                 bit_val;
    logic                 done;

    logic                 in_beat;
    logic                 out_beat;
    logic                 buf_free;
    logic                 dec_fire;

    assign out_beat        = o_m_axis_tvalid && i_m_axis_tready;
    assign buf_free        = (r_res_cnt == '0) ||
                             ((r_res_cnt == RES_CNT_W'(1)) && i_m_axis_tready);
    assign dec_fire        = r_in_vld && buf_free;
    assign o_s_axis_tready = !r_in_vld || dec_fire;
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = (r_res_cnt != '0);
    assign o_m_axis_tdata  = r_res[r_res_idx];
    assign o_m_axis_tlast  = (r_res_cnt == RES_CNT_W'(1));

    // Walk the eight bits of the held byte, MSB first
    always_comb begin
        n_st  = r_st;
        n_cnt = '0;
        for (int s = 0; s < MAX_RES; s++) begin
            slot_neg[s]  = 1'b0;
            slot_quot[s] = '0;
            slot_rem[s]  = '0;
        end
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            bit_val = r_in_byte[i];
            done    = 1'b0;
            case (n_st.phase)
                PH_QUOT: begin
                    if (bit_val) begin
                        n_st.quot = n_st.quot + QUOT_W'(1);
                    end else if (r_k == '0) begin
                        done = 1'b1;
                    end else begin
                        n_st.left  = r_k;
                        n_st.rem   = '0;
                        n_st.phase = PH_REM;
                    end
                end
                PH_REM: begin
                    n_st.rem  = {n_st.rem[REM_W-2:0], bit_val};
                    n_st.left = n_st.left - K_W'(1);
                    if (n_st.left == '0) begin
                        done = 1'b1;
                    end
                end
                default: begin
                    n_st.neg   = bit_val;
                    n_st.quot  = '0;
                    n_st.rem   = '0;
                    n_st.left  = '0;
                    n_st.phase = PH_QUOT;
                end
            endcase
            // Capture a finished code into the next free slot
            if (done && (n_cnt < RES_CNT_W'(MAX_RES))) begin
                slot_neg[n_cnt[RES_IDX_W-1:0]]  = n_st.neg;
                slot_quot[n_cnt[RES_IDX_W-1:0]] = n_st.quot;
                slot_rem[n_cnt[RES_IDX_W-1:0]]  = n_st.rem;
                n_cnt = n_cnt + RES_CNT_W'(1);
                n_st  = '{phase: PH_SIGN, neg: 1'b0, quot: '0, rem: '0, left: '0};
            end
        end
        for (int s = 0; s < MAX_RES; s++) begin
            n_res[s] = f_sample(slot_neg[s], slot_quot[s], slot_rem[s], r_k);
        end
    end

    // Hold the configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= RESET_K;
        end else if (i_cfg_we) begin
            r_k <= i_cfg_wdata;
        end
    end

    // Input register: take a beat when empty or when the decode stage moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_beat) begin
            r_in_vld <= 1'b1;
        end else if (dec_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    // Advance decoder state and load or drain the result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= '{phase: PH_SIGN, neg: 1'b0, quot: '0, rem: '0, left: '0};
            r_res_cnt <= '0;
            r_res_idx <= '0;
        end else if (dec_fire) begin
            r_st      <= n_st;
            r_res_cnt <= n_cnt;
            r_res_idx <= '0;
        end else if (out_beat) begin
            r_res_cnt <= r_res_cnt - RES_CNT_W'(1);
            r_res_idx <= r_res_idx + RES_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_fire) begin
            r_res <= n_res;
        end
    end

    // Buffer never holds more than it has slots
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_cnt <= RES_CNT_W'(MAX_RES))
        else $error("result count above buffer depth");

    // Read index plus pending samples stays inside the buffer
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ({1'b0, r_res_idx} + RES_CNT_W'(r_res_cnt)) <= RES_CNT_W'(MAX_RES))
        else $error("result index runs past buffer");

    // A held byte not yet decoded is never dropped
    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !dec_fire) |=> (r_in_vld && $stable(r_in_byte)))
        else $error("held input byte lost");

    // Decoding a byte loads exactly its sample count
    a_load_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dec_fire |=> (r_res_cnt == $past(n_cnt)) && (r_res_idx == '0))
        else $error("result buffer load mismatch");

    // The unused phase code is never entered
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase != 2'd3)
        else $error("decoder in unused phase");

endmodule

@@ verif/sign_magnitude_rice_decoder_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the sign-magnitude Rice decoder: a bit-level
// decode predictor with a sample scoreboard, plus stream drivers with gaps.
// Depends on smrd_pkg and the sign_magnitude_rice_decoder RTL.

package smrd_tb_pkg;
    import smrd_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_sample_beat;

    // Decode state tracker and queue of samples still owed by the block
    class sample_scoreboard;
        logic [K_W-1:0]    k;
        logic [1:0]        phase;
        logic              neg;
        logic [QUOT_W-1:0] quot;
        logic [REM_W-1:0]  rem;
        logic [K_W-1:0]    left;
        t_sample_beat      owed_samples[$];
        int                mismatches;

        function new();
            k          = RESET_K;
            phase      = PH_SIGN;
            neg        = 1'b0;
            quot       = '0;
            rem        = '0;
            left       = '0;
            mismatches = 0;
        endfunction

        function void set_param(logic [K_W-1:0] value);
            k = value;
        endfunction

        function int pending();
            return owed_samples.size();
        endfunction

        // Build the sample with the shift in force now, then clear the code
        function logic [SAMPLE_W-1:0] close_code();
            logic [31:0]         wide;
            logic [SAMPLE_W-1:0] mag;
            wide = 32'(quot) << k;
            mag  = wide[SAMPLE_W-1:0] | SAMPLE_W'(rem);
            if (neg) begin
                mag = SAMPLE_W'(0) - mag;
            end
            phase = PH_SIGN;
            neg   = 1'b0;
            quot  = '0;
            rem   = '0;
            left  = '0;
            return mag;
        endfunction

        // Walk one accepted byte MSB first and queue every sample it closes
        function void note_byte(logic [BYTE_W-1:0] code_byte);
            t_sample_beat beat;
            logic         bit_in;
            logic         done;
            int           closed;
            closed = 0;
            for (int i = BYTE_W - 1; i >= 0; i--) begin
                bit_in = code_byte[i];
                done   = 1'b0;
                case (phase)
                    PH_QUOT: begin
                        if (bit_in) begin
                            quot = quot + QUOT_W'(1);
                        end else if (k == '0) begin
                            done = 1'b1;
                        end else begin
                            left  = k;
                            rem   = '0;
                            phase = PH_REM;
                        end
                    end
                    PH_REM: begin
                        rem  = {rem[REM_W-2:0], bit_in};
                        left = left - K_W'(1);
                        if (left == '0) begin
                            done = 1'b1;
                        end
                    end
                    default: begin
                        neg   = bit_in;
                        quot  = '0;
                        rem   = '0;
                        left  = '0;
                        phase = PH_QUOT;
                    end
                endcase
                if (done) begin
                    beat.sample  = close_code();
                    beat.last    = 1'b0;
                    owed_samples = {owed_samples, beat};
                    closed++;
                end
            end
            // Mark the final sample closed within this byte
            if (closed > 0) begin
                owed_samples[owed_samples.size() - 1].last = 1'b1;
            end
        endfunction

        function void flag_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t mismatch: %s", $time, msg);
            end
        endfunction

        // Compare one output beat with the oldest owed sample
        function void check_sample(logic [SAMPLE_W-1:0] sample, logic last);
            t_sample_beat want;
            if (owed_samples.size() == 0) begin
                flag_mismatch($sformatf("unexpected sample %h last %b", sample, last));
                return;
            end
            want = owed_samples.pop_front();
            if (sample !== want.sample) begin
                flag_mismatch($sformatf("sample expected %h actual %h",
                                        want.sample, sample));
            end
            if (last !== want.last) begin
                flag_mismatch($sformatf("tlast expected %b actual %b (sample %h)",
                                        want.last, last, want.sample));
            end
        endfunction
    endclass
endpackage

module sign_magnitude_rice_decoder_tb;
    import smrd_pkg::*;
    import smrd_tb_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int RAND_PHASES     = 8;
    localparam int PHASE_BYTES     = 30;
    localparam int LONG_QUOT_BYTES = 16;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_we        = 1'b0;
    logic [K_W-1:0]      i_cfg_wdata     = '0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [BYTE_W-1:0]   i_s_axis_tdata  = '0;   // [7:0] code_byte
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0] o_m_axis_tdata;         // [15:0] sample
    logic                o_m_axis_tlast;         // last_of_byte

    sample_scoreboard sb = new();

    bit             in_gaps_on    = 1'b1;
    bit             out_stalls_on = 1'b1;
    logic [K_W-1:0] cur_k         = RESET_K;
    bit             code_bits[$];
    int             cycle_count   = 0;

    sign_magnitude_rice_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Mostly short pauses, a few long ones
    function automatic int pick_pause(bit enabled, int long_max);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55) begin
            return 0;
        end else if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, long_max);
    endfunction

    // Offer one byte, hold it until taken, then maybe pause
    task automatic send_byte(input logic [BYTE_W-1:0] code_byte);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= code_byte;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        sb.note_byte(code_byte);
        gap = pick_pause(in_gaps_on, 30);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Write k once every owed sample is out and the pipeline has settled
    task automatic write_rice_param(input logic [K_W-1:0] value);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_param(value);
        cur_k = value;
    endtask

    // Append one well-formed code for the current k to the bit stream
    function automatic void push_code(bit neg, int quot, logic [REM_W-1:0] rem);
        code_bits = {code_bits, neg};
        repeat (quot) code_bits = {code_bits, 1'b1};
        code_bits = {code_bits, 1'b0};
        for (int i = int'(cur_k) - 1; i >= 0; i--) begin
            code_bits = {code_bits, rem[i]};
        end
    endfunction

    function automatic logic [BYTE_W-1:0] pop_byte();
        logic [BYTE_W-1:0] b;
        b = '0;
        repeat (BYTE_W) b = {b[BYTE_W-2:0], code_bits.pop_front()};
        return b;
    endfunction

    // Output side: random ready with stalls of random length
    initial begin
        int run;
        int stall;
        forever begin
            i_m_axis_tready <= 1'b1;
            run = out_stalls_on ? $urandom_range(1, 6) : 16;
            repeat (run) @(posedge i_clk);
            stall = pick_pause(out_stalls_on, 40);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Check every sample beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_sample(o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[sign_magnitude_rice_decoder] ERROR");
            $finish;
        end
    end

    initial begin
        logic [BYTE_W-1:0] seq_k5  [9] = '{8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA,
                                          8'h80, 8'h7F, 8'h01, 8'hFE};
        logic [BYTE_W-1:0] seq_k0  [6] = '{8'h00, 8'hAA, 8'h88, 8'hFF, 8'h40, 8'hC0};
        logic [BYTE_W-1:0] seq_k15 [9] = '{8'hBF, 8'hFF, 8'hFF, 8'h7F, 8'hFF,
                                          8'hFF, 8'h00, 8'h00, 8'hC0};
        logic [K_W-1:0]    next_k;
        logic [REM_W-1:0]  rem;
        int                sent;
        int                qsel;
        int                quot;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset k, then zero k, then widest k
        foreach (seq_k5[i]) send_byte(seq_k5[i]);
        write_rice_param(K_W'(0));
        foreach (seq_k0[i]) send_byte(seq_k0[i]);
        write_rice_param(K_W'(15));
        foreach (seq_k15[i]) send_byte(seq_k15[i]);

        // Change k while a remainder is half read, then finish that code
        write_rice_param(K_W'(2));
        send_byte(8'hFF);
        send_byte(8'hFF);

        // Run a long quotient at full input rate, then end the code
        in_gaps_on = 1'b0;
        repeat (LONG_QUOT_BYTES) send_byte(8'hFF);
        send_byte(8'h00);

        // Random phases: mostly generated codes, some raw noise bytes
        for (int p = 0; p < RAND_PHASES; p++) begin
            next_k = (p == 0) ? K_W'(0) : (p == 1) ? K_W'(15) :
                     K_W'($urandom_range(0, 15));
            write_rice_param(next_k);
            in_gaps_on    = (p % 3) != 2;
            out_stalls_on = (p % 4) != 1;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                if ($urandom_range(0, 99) < 80) begin
                    qsel = $urandom_range(0, 99);
                    quot = (qsel < 85) ? $urandom_range(0, 3) :
                           (qsel < 97) ? $urandom_range(4, 20) : $urandom_range(21, 60);
                    rem  = REM_W'($urandom);
                    push_code(1'($urandom_range(0, 1)), quot, rem);
                end else begin
                    repeat (BYTE_W) code_bits = {code_bits, 1'($urandom_range(0, 1))};
                end
                while (code_bits.size() >= BYTE_W) begin
                    send_byte(pop_byte());
                    sent++;
                end
            end
        end

        // Pad the tail to a byte; any partial code stays in the block
        if (code_bits.size() > 0) begin
            while (code_bits.size() < BYTE_W) begin
                code_bits = {code_bits, 1'($urandom_range(0, 1))};
            end
            send_byte(pop_byte());
        end

        // Drain
        i_s_axis_tvalid <= 1'b0;
        out_stalls_on = 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("[sign_magnitude_rice_decoder] OK");
        end else begin
            $display("[sign_magnitude_rice_decoder] ERROR");
        end
        $finish;
    end

endmodule
